// ===== rtl/core/rci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_pkg
// Shared types, register codes and Q16.16 helpers for the ray/cylinder test.
// ----------------------------------------------------------------------------
package rci_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int SQ_STEPS        = 24;
    localparam int DIV_STEPS       = 50;

    typedef enum logic [2:0] {
        REG_POS_X  = 3'd0,
        REG_POS_Y  = 3'd1,
        REG_POS_Z  = 3'd2,
        REG_AXIS_X = 3'd3,
        REG_AXIS_Y = 3'd4,
        REG_AXIS_Z = 3'd5,
        REG_RADIUS = 3'd6,
        REG_ENABLE = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [17:0] ax;
        logic signed [17:0] ay;
        logic signed [17:0] az;
        logic        [30:0] radius;
        logic               enable;
    } cfg_t;

    typedef struct packed {
        logic               miss;
        logic        [30:0] best;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] disc;
    } q_item_t;

    // Q16.16 product rescale, round to nearest, ties away from zero
    function automatic logic signed [47:0] rq(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [47:0] q;
        mag = p[63] ? 64'(-p) : 64'(p);
        q   = 48'((mag + 64'd32768) >> 16);
        rq  = p[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

// ===== rtl/core/rci_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_front
// Seven-stage front: forms the quadratic terms and discriminant, flags misses.
// ----------------------------------------------------------------------------
module rci_front (
    input  logic                clk,
    input  logic                rst_n,
    input  rci_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  org_x,
    input  logic signed [31:0]  org_y,
    input  logic signed [31:0]  org_z,
    input  logic signed [17:0]  dir_x,
    input  logic signed [17:0]  dir_y,
    input  logic signed [17:0]  dir_z,
    input  logic        [30:0]  best_dist,
    input  logic                full,
    output logic                push,
    output rci_pkg::q_item_t    push_item
);
    import rci_pkg::*;

    logic adv;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic        [30:0] best1_reg, best2_reg, best3_reg, best4_reg, best5_reg, best6_reg;
    logic signed [31:0] x1x_reg, x1y_reg, x1z_reg;
    logic signed [17:0] d1x_reg, d1y_reg, d1z_reg;
    logic signed [63:0] pdv_reg [3];
    logic signed [63:0] pxv_reg [3];
    logic signed [63:0] pdx_reg [3];
    logic signed [63:0] pxx_reg [3];
    logic signed [31:0] dv3_reg, xv3_reg, dX3_reg, XX3_reg;
    logic signed [31:0] dX4_reg, XX4_reg;
    logic signed [63:0] mdd_reg, mdx_reg, mxx_reg, mrr_reg;
    logic signed [31:0] a5_reg, b5_reg, c5_reg;
    logic signed [31:0] a6_reg, b6_reg;
    logic signed [63:0] mbb_reg, mac_reg;
    q_item_t            item7_reg;

    assign adv       = !full;
    assign in_ready  = adv;
    assign push      = v7_reg && adv;
    assign push_item = item7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: origin relative to base point
            x1x_reg   <= sat32(64'(org_x) - 64'(cfg.pos_x));
            x1y_reg   <= sat32(64'(org_y) - 64'(cfg.pos_y));
            x1z_reg   <= sat32(64'(org_z) - 64'(cfg.pos_z));
            d1x_reg   <= dir_x;
            d1y_reg   <= dir_y;
            d1z_reg   <= dir_z;
            best1_reg <= best_dist;

            // stage 2: dot product terms
            pdv_reg[0] <= 64'(d1x_reg) * 64'(cfg.ax);
            pdv_reg[1] <= 64'(d1y_reg) * 64'(cfg.ay);
            pdv_reg[2] <= 64'(d1z_reg) * 64'(cfg.az);
            pxv_reg[0] <= 64'(x1x_reg) * 64'(cfg.ax);
            pxv_reg[1] <= 64'(x1y_reg) * 64'(cfg.ay);
            pxv_reg[2] <= 64'(x1z_reg) * 64'(cfg.az);
            pdx_reg[0] <= 64'(d1x_reg) * 64'(x1x_reg);
            pdx_reg[1] <= 64'(d1y_reg) * 64'(x1y_reg);
            pdx_reg[2] <= 64'(d1z_reg) * 64'(x1z_reg);
            pxx_reg[0] <= 64'(x1x_reg) * 64'(x1x_reg);
            pxx_reg[1] <= 64'(x1y_reg) * 64'(x1y_reg);
            pxx_reg[2] <= 64'(x1z_reg) * 64'(x1z_reg);
            best2_reg  <= best1_reg;

            // stage 3: dot sums
            dv3_reg   <= sat32(64'(rq(pdv_reg[0])) + 64'(rq(pdv_reg[1])) + 64'(rq(pdv_reg[2])));
            xv3_reg   <= sat32(64'(rq(pxv_reg[0])) + 64'(rq(pxv_reg[1])) + 64'(rq(pxv_reg[2])));
            dX3_reg   <= sat32(64'(rq(pdx_reg[0])) + 64'(rq(pdx_reg[1])) + 64'(rq(pdx_reg[2])));
            XX3_reg   <= sat32(64'(rq(pxx_reg[0])) + 64'(rq(pxx_reg[1])) + 64'(rq(pxx_reg[2])));
            best3_reg <= best2_reg;

            // stage 4
            mdd_reg   <= 64'(dv3_reg) * 64'(dv3_reg);
            mdx_reg   <= 64'(dv3_reg) * 64'(xv3_reg);
            mxx_reg   <= 64'(xv3_reg) * 64'(xv3_reg);
            mrr_reg   <= $signed({33'd0, cfg.radius}) * $signed({33'd0, cfg.radius});
            dX4_reg   <= dX3_reg;
            XX4_reg   <= XX3_reg;
            best4_reg <= best3_reg;

            // stage 5: quadratic coefficients
            a5_reg    <= sat32(64'(rq(mdd_reg)) - 64'sd65536);
            b5_reg    <= sat32(64'sd2 * (64'(rq(mdx_reg)) - 64'(dX4_reg)));
            c5_reg    <= sat32(64'(rq(mxx_reg)) - 64'(XX4_reg) + 64'(rq(mrr_reg)));
            best5_reg <= best4_reg;

            // stage 6
            mbb_reg   <= 64'(b5_reg) * 64'(b5_reg);
            mac_reg   <= 64'(a5_reg) * 64'(c5_reg);
            a6_reg    <= a5_reg;
            b6_reg    <= b5_reg;
            best6_reg <= best5_reg;

            // stage 7: discriminant and miss test
            item7_reg.disc <= sat32(64'(rq(mbb_reg)) - 64'sd4 * 64'(rq(mac_reg)));
            item7_reg.miss <= !cfg.enable || (a6_reg == 32'sd0) ||
                              (sat32(64'(rq(mbb_reg)) - 64'sd4 * 64'(rq(mac_reg))) < 32'sd0);
            item7_reg.a    <= a6_reg;
            item7_reg.b    <= b6_reg;
            item7_reg.best <= best6_reg;
        end
    end

endmodule

// ===== rtl/core/rci_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_queue
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module rci_queue #(
    parameter int DEPTH = rci_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rci_pkg::q_item_t  push_item,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output rci_pkg::q_item_t  head
);
    import rci_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_item_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty)) else $error("queue underflow");

endmodule

// ===== rtl/core/rci_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_back
// Back pipeline: bit-serial square root, two restoring dividers, root select.
// ----------------------------------------------------------------------------
module rci_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  rci_pkg::q_item_t  item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output logic [30:0]       new_dist
);
    import rci_pkg::*;

    typedef struct packed {
        logic        miss;
        logic [30:0] best;
        logic        neg0;
        logic        neg1;
        logic [32:0] dvs;
        logic [49:0] dvd0;
        logic [49:0] dvd1;
    } div_item_t;

    logic adv;

    logic        sq_vld_reg  [SQ_STEPS+1];
    q_item_t     sq_item_reg [SQ_STEPS+1];
    logic [25:0] sq_rem_reg  [SQ_STEPS+1];
    logic [23:0] sq_root_reg [SQ_STEPS+1];

    logic        dv_vld_reg  [DIV_STEPS+1];
    div_item_t   dv_item_reg [DIV_STEPS+1];
    logic [32:0] dv_r0_reg   [DIV_STEPS+1];
    logic [32:0] dv_r1_reg   [DIV_STEPS+1];
    logic [49:0] dv_q0_reg   [DIV_STEPS+1];
    logic [49:0] dv_q1_reg   [DIV_STEPS+1];

    logic        out_vld_reg;
    logic        hit_reg;
    logic [30:0] dist_reg;

    logic signed [63:0] n0, n1, mag0, mag1, mag_a;
    logic signed [31:0] t0, t1, tmin;
    div_item_t          fin;

    assign adv       = !out_vld_reg || out_ready;
    assign pop       = adv && item_valid;
    assign out_valid = out_vld_reg;
    assign hit       = hit_reg;
    assign new_dist  = dist_reg;

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else if (adv)
            sq_vld_reg[0] <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_item_reg[0] <= item;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // square root of disc * 2^16, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam int PIDX = SQ_STEPS - 1 - k;
        logic [47:0] nx;
        logic [27:0] rem_sh, trial;
        logic        ge;

        assign nx     = {sq_item_reg[k].disc, 16'd0};
        assign rem_sh = {sq_rem_reg[k], nx[2*PIDX+1 -: 2]};
        assign trial  = {2'b00, sq_root_reg[k], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k+1] <= 1'b0;
            else if (adv)
                sq_vld_reg[k+1] <= sq_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_item_reg[k+1] <= sq_item_reg[k];
                sq_rem_reg[k+1]  <= ge ? 26'(rem_sh - trial) : rem_sh[25:0];
                sq_root_reg[k+1] <= {sq_root_reg[k][22:0], ge};
            end
        end
    end

    // divider setup: roots are (-b +/- s) * 2^16 / 2a, rounded half away
    always_comb
    begin
        n0    = -64'(sq_item_reg[SQ_STEPS].b) + 64'(sq_root_reg[SQ_STEPS]);
        n1    = -64'(sq_item_reg[SQ_STEPS].b) - 64'(sq_root_reg[SQ_STEPS]);
        mag0  = n0[63] ? -n0 : n0;
        mag1  = n1[63] ? -n1 : n1;
        mag_a = sq_item_reg[SQ_STEPS].a[31] ? -64'(sq_item_reg[SQ_STEPS].a)
                                            : 64'(sq_item_reg[SQ_STEPS].a);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (adv)
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_item_reg[0].miss <= sq_item_reg[SQ_STEPS].miss;
            dv_item_reg[0].best <= sq_item_reg[SQ_STEPS].best;
            dv_item_reg[0].neg0 <= n0[63] != sq_item_reg[SQ_STEPS].a[31];
            dv_item_reg[0].neg1 <= n1[63] != sq_item_reg[SQ_STEPS].a[31];
            dv_item_reg[0].dvs  <= 33'(mag_a <<< 1);
            dv_item_reg[0].dvd0 <= 50'((mag0 <<< 16) + mag_a);
            dv_item_reg[0].dvd1 <= 50'((mag1 <<< 16) + mag_a);
            dv_r0_reg[0]        <= '0;
            dv_r1_reg[0]        <= '0;
            dv_q0_reg[0]        <= '0;
            dv_q1_reg[0]        <= '0;
        end
    end

    // restoring division, one quotient bit per stage, both roots in step
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int BIDX = DIV_STEPS - 1 - j;
        logic [33:0] sh0, sh1, dvs_x;
        logic        ge0, ge1;

        assign dvs_x = {1'b0, dv_item_reg[j].dvs};
        assign sh0   = {dv_r0_reg[j], dv_item_reg[j].dvd0[BIDX]};
        assign sh1   = {dv_r1_reg[j], dv_item_reg[j].dvd1[BIDX]};
        assign ge0   = (sh0 >= dvs_x);
        assign ge1   = (sh1 >= dvs_x);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j+1] <= 1'b0;
            else if (adv)
                dv_vld_reg[j+1] <= dv_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_item_reg[j+1] <= dv_item_reg[j];
                dv_r0_reg[j+1]   <= ge0 ? 33'(sh0 - dvs_x) : sh0[32:0];
                dv_r1_reg[j+1]   <= ge1 ? 33'(sh1 - dvs_x) : sh1[32:0];
                dv_q0_reg[j+1]   <= {dv_q0_reg[j][48:0], ge0};
                dv_q1_reg[j+1]   <= {dv_q1_reg[j][48:0], ge1};
            end
        end
    end

    // root select and distance compare
    always_comb
    begin
        fin  = dv_item_reg[DIV_STEPS];
        t0   = sat32(fin.neg0 ? -$signed(64'(dv_q0_reg[DIV_STEPS]))
                              :  $signed(64'(dv_q0_reg[DIV_STEPS])));
        t1   = sat32(fin.neg1 ? -$signed(64'(dv_q1_reg[DIV_STEPS]))
                              :  $signed(64'(dv_q1_reg[DIV_STEPS])));
        tmin = (t0 < t1) ? t0 : t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= dv_vld_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (!fin.miss && (tmin > 32'sd0) && (tmin < $signed({1'b0, fin.best})))
            begin
                hit_reg  <= 1'b1;
                dist_reg <= tmin[30:0];
            end
            else
            begin
                hit_reg  <= 1'b0;
                dist_reg <= fin.best;
            end
        end
    end

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && hit_reg |-> dist_reg != 31'd0) else $error("hit with zero distance");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> sq_vld_reg[0]) else $error("popped item lost at entry");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(dv_vld_reg[DIV_STEPS])) else $error("pipeline moved during stall");

endmodule

// ===== rtl/core/ray_cylinder_intersect_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_cylinder_intersect_top
// Ray against one infinite cylinder, signed Q16.16, saturating.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one ray item per cycle while
//   in_ready is high: origin, unit direction and best distance so far.
//   Output channel (out_valid/out_ready) returns one item per ray, in order:
//   hit and new_dist. Configuration channel (cfg_valid/cfg_ready/cfg_index/
//   cfg_data) writes the cylinder registers; cfg_ready is always high.
//   Write only while idle. Throughput: one item per cycle while out_ready
//   stays high. With no stall, a ray passes from the edge that accepts it to
//   its result through 7 front stages, the queue, a square-root entry stage,
//   24 square-root stages (one root bit each), a setup stage, 50 divider
//   stages (one quotient bit each) and the output register.
//   Reset clears all valid state and loads the register defaults (cylinder
//   disabled, axis +y, radius 1.0).
//   When the receiver stalls the back pipeline holds; the front keeps
//   accepting until the queue between them fills, then in_ready drops.
// ----------------------------------------------------------------------------
module ray_cylinder_intersect_top #(
    parameter int QUEUE_DEPTH = rci_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] org_x,
    input  logic signed [31:0] org_y,
    input  logic signed [31:0] org_z,
    input  logic signed [17:0] dir_x,
    input  logic signed [17:0] dir_y,
    input  logic signed [17:0] dir_z,
    input  logic        [30:0] best_dist,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic        [30:0] new_dist
);
    import rci_pkg::*;

    cfg_t    cfg_reg;
    logic    full, push, pop, not_empty;
    q_item_t push_item, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x  <= '0;
            cfg_reg.pos_y  <= '0;
            cfg_reg.pos_z  <= '0;
            cfg_reg.ax     <= '0;
            cfg_reg.ay     <= 18'sd65536;
            cfg_reg.az     <= '0;
            cfg_reg.radius <= 31'd65536;
            cfg_reg.enable <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_POS_X:  cfg_reg.pos_x  <= cfg_data;
                REG_POS_Y:  cfg_reg.pos_y  <= cfg_data;
                REG_POS_Z:  cfg_reg.pos_z  <= cfg_data;
                REG_AXIS_X: cfg_reg.ax     <= cfg_data[17:0];
                REG_AXIS_Y: cfg_reg.ay     <= cfg_data[17:0];
                REG_AXIS_Z: cfg_reg.az     <= cfg_data[17:0];
                REG_RADIUS: cfg_reg.radius <= cfg_data[30:0];
                REG_ENABLE: cfg_reg.enable <= cfg_data[0];
                default:    cfg_reg.enable <= cfg_reg.enable;
            endcase
        end
    end

    rci_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .org_x     (org_x),
        .org_y     (org_y),
        .org_z     (org_z),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .best_dist (best_dist),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    rci_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    rci_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (not_empty),
        .item       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .new_dist   (new_dist)
    );

endmodule
